/* hw/rtl/wave_header_parser_checker_core_macros.svh */
// Assertion macros shared by the wave header parser RTL.
// Needs nothing but the including module's clk and rst_n.
`ifndef WAVE_HEADER_PARSER_CHECKER_CORE_MACROS_SVH
`define WAVE_HEADER_PARSER_CHECKER_CORE_MACROS_SVH
// Implication checked on every clock, held off during reset.
`define WHP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, held off during reset.
`define WHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/whp_pkg.sv */
// Shared types and constants of the wave header parser.
// No dependencies.
package whp_pkg;
    typedef enum logic [3:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_FID, PH_FLEN, PH_OLEN_F, PH_SKIP_F,
        PH_FIELDS, PH_EXTRA, PH_DID, PH_DLEN, PH_OLEN_D, PH_SKIP_D
    } phase_t;

    typedef enum logic [1:0] {
        FIN_IDLE, FIN_MUL, FIN_CHECK
    } fin_state_t;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_AIFF = 3'd1;
    localparam logic [2:0] ST_NO_RIFF = 3'd2;
    localparam logic [2:0] ST_NO_WAVE = 3'd3;
    localparam logic [2:0] ST_EARLY_END = 3'd4;
    localparam logic [2:0] ST_FMT_SHORT = 3'd5;
    localparam logic [2:0] ST_NOT_PCM = 3'd6;

    localparam logic [1:0] CFG_FILE_SIZE = 2'd0;
    localparam logic [1:0] CFG_SIZE_CHECK = 2'd1;
    localparam logic [1:0] CFG_MIN_CD = 2'd2;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_FORM = 32'h4D52_4F46;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [31:0] CANON_HEADER = 32'd44;
    localparam logic [31:0] CD_SECTOR = 32'd2352;
    localparam logic [31:0] CD_RATE_HZ = 32'd44100;
    localparam logic [31:0] CD_BYTE_RATE = 32'd176400;

    // Sector size is 16 * 147; the odd factor is tested by reciprocal multiplication.
    // ceil(2^36 / 147) gives the exact quotient for any 28-bit dividend.
    localparam logic [7:0]  CD_SECTOR_ODD = 8'd147;
    localparam logic [28:0] CD_SECTOR_RECIP = 29'd467479434;

    // Parsed header handed from the front part to the check unit
    typedef struct packed {
        logic        is_final;
        logic [2:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] avg_bytes_rate;
        logic [15:0] block_alignment;
        logic [15:0] sample_bits;
        logic [31:0] riff_size;
        logic [31:0] payload_size;
        logic [31:0] header_length;
    } hdr_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] avg_bytes_rate;
        logic [15:0] block_alignment;
        logic [15:0] sample_bits;
        logic [31:0] riff_size;
        logic [31:0] payload_size;
        logic [31:0] header_length;
        logic [8:0]  problem_flags;
    } res_t;
endpackage

/* hw/rtl/whp_front.sv */
// Byte-level front part: walks the RIFF/WAVE chunk structure one byte a cycle when not stalled.
// Depends on whp_pkg.
module whp_front
    import whp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_kind,
    input  logic [7:0] in_byte,
    output logic       hdr_valid,
    input  logic       hdr_ready,
    output hdr_t       hdr
);
    phase_t      phase_reg, phase_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] flen_reg, flen_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] rsize_reg, rsize_next;
    logic [15:0] fmt_reg, fmt_next, ch_reg, ch_next, al_reg, al_next, bits_reg, bits_next;
    logic [31:0] sr_reg, sr_next, avg_reg, avg_next;
    logic        sent_reg, sent_next;
    logic        hv_reg, hv_next;
    hdr_t        hdr_reg, hdr_next;

    logic        take;
    logic [31:0] w;
    logic        wdone;
    logic [3:0]  off;
    logic [31:0] skip_dec;

    // Output register frees the front when the back takes the header
    assign in_ready = !hv_reg || hdr_ready;
    assign take = in_valid && in_ready;
    assign hdr_valid = hv_reg;
    assign hdr = hdr_reg;

    always_comb
    begin
        w = word_reg | ({24'd0, in_byte} << {pos_reg, 3'b000});
        wdone = (pos_reg == 2'd3);
        off = 4'(FMT_MIN_LEN - skip_reg);
        skip_dec = skip_reg - 32'd1;

        phase_next = phase_reg;
        pos_next = pos_reg;
        word_next = word_reg;
        skip_next = skip_reg;
        flen_next = flen_reg;
        count_next = count_reg;
        rsize_next = rsize_reg;
        fmt_next = fmt_reg;
        ch_next = ch_reg;
        sr_next = sr_reg;
        avg_next = avg_reg;
        al_next = al_reg;
        bits_next = bits_reg;
        sent_next = sent_reg;
        hv_next = hv_reg && !hdr_ready;
        hdr_next = hdr_reg;

        // Snapshot of held fields; status and payload filled below
        if (take)
        begin
            hdr_next.format_tag = fmt_reg;
            hdr_next.channels = ch_reg;
            hdr_next.sample_rate = sr_reg;
            hdr_next.avg_bytes_rate = avg_reg;
            hdr_next.block_alignment = al_reg;
            hdr_next.sample_bits = bits_reg;
            hdr_next.riff_size = rsize_reg;
            hdr_next.payload_size = '0;
            hdr_next.header_length = count_reg + 32'd1;
            hdr_next.is_final = 1'b0;
            hdr_next.status = ST_OK;
        end

        if (take && in_kind)
        begin
            // End of stream: report if nothing sent, then rearm
            if (!sent_reg)
            begin
                hv_next = 1'b1;
                hdr_next.header_length = count_reg;
                hdr_next.status = (phase_reg == PH_RIFF) ? ST_NO_RIFF :
                                  (phase_reg == PH_WAVE) ? ST_NO_WAVE : ST_EARLY_END;
            end
            phase_next = PH_RIFF;
            pos_next = '0;
            word_next = '0;
            skip_next = '0;
            flen_next = '0;
            count_next = '0;
            rsize_next = '0;
            fmt_next = '0;
            ch_next = '0;
            sr_next = '0;
            avg_next = '0;
            al_next = '0;
            bits_next = '0;
            sent_next = 1'b0;
        end
        else if (take && !sent_reg)
        begin
            count_next = count_reg + 32'd1;
            if (phase_reg != PH_FIELDS && phase_reg != PH_SKIP_F &&
                phase_reg != PH_SKIP_D && phase_reg != PH_EXTRA)
            begin
                pos_next = pos_reg + 2'd1;
                word_next = wdone ? 32'd0 : w;
            end
            case (phase_reg)
                PH_RIFF:
                    if (wdone)
                    begin
                        if (w == TAG_RIFF)
                            phase_next = PH_RSIZE;
                        else
                        begin
                            hv_next = 1'b1;
                            sent_next = 1'b1;
                            hdr_next.status = (w == TAG_FORM) ? ST_AIFF : ST_NO_RIFF;
                        end
                    end
                PH_RSIZE:
                    if (wdone)
                    begin
                        rsize_next = w;
                        phase_next = PH_WAVE;
                    end
                PH_WAVE:
                    if (wdone)
                    begin
                        if (w != TAG_WAVE)
                        begin
                            hv_next = 1'b1;
                            sent_next = 1'b1;
                            hdr_next.status = ST_NO_WAVE;
                        end
                        else
                            phase_next = PH_FID;
                    end
                PH_FID:
                    if (wdone)
                        phase_next = (w == TAG_FMT) ? PH_FLEN : PH_OLEN_F;
                PH_DID:
                    if (wdone)
                        phase_next = (w == TAG_DATA) ? PH_DLEN : PH_OLEN_D;
                PH_OLEN_F, PH_OLEN_D:
                    if (wdone)
                    begin
                        skip_next = w;
                        if (w == 32'd0)
                            phase_next = (phase_reg == PH_OLEN_F) ? PH_FID : PH_DID;
                        else
                            phase_next = (phase_reg == PH_OLEN_F) ? PH_SKIP_F : PH_SKIP_D;
                    end
                PH_SKIP_F, PH_SKIP_D, PH_EXTRA:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                        phase_next = (phase_reg == PH_SKIP_F) ? PH_FID : PH_DID;
                end
                PH_FLEN:
                    if (wdone)
                    begin
                        flen_next = w;
                        if (w < FMT_MIN_LEN)
                        begin
                            hv_next = 1'b1;
                            sent_next = 1'b1;
                            hdr_next.status = ST_FMT_SHORT;
                        end
                        else
                        begin
                            skip_next = FMT_MIN_LEN;
                            phase_next = PH_FIELDS;
                        end
                    end
                PH_FIELDS:
                begin
                    // Deposit one format byte at its field and lane
                    case (off)
                        4'd0: fmt_next[7:0] = fmt_reg[7:0] | in_byte;
                        4'd1: fmt_next[15:8] = fmt_reg[15:8] | in_byte;
                        4'd2: ch_next[7:0] = ch_reg[7:0] | in_byte;
                        4'd3: ch_next[15:8] = ch_reg[15:8] | in_byte;
                        4'd4: sr_next[7:0] = sr_reg[7:0] | in_byte;
                        4'd5: sr_next[15:8] = sr_reg[15:8] | in_byte;
                        4'd6: sr_next[23:16] = sr_reg[23:16] | in_byte;
                        4'd7: sr_next[31:24] = sr_reg[31:24] | in_byte;
                        4'd8: avg_next[7:0] = avg_reg[7:0] | in_byte;
                        4'd9: avg_next[15:8] = avg_reg[15:8] | in_byte;
                        4'd10: avg_next[23:16] = avg_reg[23:16] | in_byte;
                        4'd11: avg_next[31:24] = avg_reg[31:24] | in_byte;
                        4'd12: al_next[7:0] = al_reg[7:0] | in_byte;
                        4'd13: al_next[15:8] = al_reg[15:8] | in_byte;
                        4'd14: bits_next[7:0] = bits_reg[7:0] | in_byte;
                        default: bits_next[15:8] = bits_reg[15:8] | in_byte;
                    endcase
                    skip_next = skip_dec;
                    if (off == 4'd1 && fmt_next != 16'd1)
                    begin
                        hv_next = 1'b1;
                        sent_next = 1'b1;
                        hdr_next.status = ST_NOT_PCM;
                        hdr_next.format_tag = fmt_next;
                    end
                    else if (skip_dec == 32'd0)
                    begin
                        skip_next = flen_reg - FMT_MIN_LEN;
                        phase_next = (flen_reg != FMT_MIN_LEN) ? PH_EXTRA : PH_DID;
                    end
                end
                PH_DLEN:
                    if (wdone)
                    begin
                        hv_next = 1'b1;
                        sent_next = 1'b1;
                        hdr_next.is_final = 1'b1;
                        hdr_next.payload_size = w;
                    end
                default:
                    phase_next = PH_RIFF;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF;
            pos_reg <= '0;
            word_reg <= '0;
            skip_reg <= '0;
            flen_reg <= '0;
            count_reg <= '0;
            rsize_reg <= '0;
            fmt_reg <= '0;
            ch_reg <= '0;
            sr_reg <= '0;
            avg_reg <= '0;
            al_reg <= '0;
            bits_reg <= '0;
            sent_reg <= 1'b0;
            hv_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            word_reg <= word_next;
            skip_reg <= skip_next;
            flen_reg <= flen_next;
            count_reg <= count_next;
            rsize_reg <= rsize_next;
            fmt_reg <= fmt_next;
            ch_reg <= ch_next;
            sr_reg <= sr_next;
            avg_reg <= avg_next;
            al_reg <= al_next;
            bits_reg <= bits_next;
            sent_reg <= sent_next;
            hv_reg <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

`include "wave_header_parser_checker_core_macros.svh"
    `WHP_ASSERT_IMPL(a_hold_stall, hv_reg && !hdr_ready, !in_ready)
    `WHP_ASSERT_NEXT(a_sent_blocks, sent_reg && take && !in_kind, !hv_reg)
    `WHP_ASSERT_IMPL(a_bytepos_skip, phase_reg == PH_EXTRA || phase_reg == PH_FIELDS,
                     pos_reg == 2'd0)
endmodule

/* hw/rtl/whp_queue.sv */
// Two-entry queue between the front part and the check unit.
// Depends on whp_pkg.
module whp_queue
    import whp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  hdr_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output hdr_t rd_data
);
    hdr_t       mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data = mem[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    // Store on push
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* hw/rtl/whp_check.sv */
// Back part: final size and quality checks, result register.
// Depends on whp_pkg and whp_mod.
module whp_check
    import whp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hdr_valid,
    output logic        hdr_ready,
    input  hdr_t        hdr,
    input  logic [31:0] file_size,
    input  logic        size_check,
    input  logic [31:0] min_cd,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);
    fin_state_t  state_reg, state_next;
    hdr_t        h_reg, h_next;
    logic [47:0] prod_reg, prod_next;
    logic [31:0] rem_al_reg, rem_al_next;
    logic        div_start, div_done_al;
    logic [56:0] cd_prod;
    logic [28:0] cd_back;
    logic [20:0] cd_q_reg;
    logic        cd_rem_nz_reg;
    logic        rv_reg, rv_next;
    res_t        res_reg, res_next;
    logic [8:0]  flags;
    logic [33:0] total, hdr_sum, padded;
    logic        is_cd;

    assign hdr_ready = (state_reg == FIN_IDLE) && (!rv_reg || res_ready);
    assign res_valid = rv_reg;
    assign res = res_reg;

    // Block-alignment remainder by an iterative unit
    whp_mod u_mod_al (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(hdr.payload_size), .divisor({16'd0, hdr.block_alignment}),
        .done(div_done_al), .remainder(rem_al_next)
    );

    // Sector remainder: quotient by reciprocal, then multiply back and compare
    always_comb
    begin
        cd_prod = 57'(h_reg.payload_size[31:4]) * 57'(CD_SECTOR_RECIP);
        cd_back = 29'(cd_q_reg) * 29'(CD_SECTOR_ODD);
    end

    always_comb
    begin
        total = {2'b00, h_reg.riff_size} + 34'd8;
        hdr_sum = {2'b00, h_reg.payload_size} + {2'b00, h_reg.header_length};
        padded = {2'b00, h_reg.payload_size} + {33'd0, h_reg.payload_size[0]}
                 + {2'b00, h_reg.header_length};
        // Rate product sr*ch is formed in FIN_MUL; bits is fixed at 16 for CD quality
        is_cd = h_reg.channels == 16'd2 && h_reg.sample_bits == 16'd16 &&
                h_reg.sample_rate == CD_RATE_HZ && h_reg.avg_bytes_rate == CD_BYTE_RATE;
        flags = '0;
        if (is_cd)
        begin
            if (h_reg.payload_size < min_cd)
                flags[0] = 1'b1;
            if (cd_rem_nz_reg)
                flags[1] = 1'b1;
        end
        else
            flags[2] = 1'b1;
        if (h_reg.header_length != CANON_HEADER)
            flags[3] = 1'b1;
        if (hdr_sum > total)
            flags[4] = 1'b1;
        if (h_reg.block_alignment == 16'd0 || rem_al_reg != 32'd0)
            flags[5] = 1'b1;
        if (size_check)
        begin
            if (total < {2'b00, file_size})
                flags[6] = 1'b1;
            if (total > {2'b00, file_size})
                flags[7] = 1'b1;
        end
        if (total > padded)
            flags[8] = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        h_next = h_reg;
        prod_next = prod_reg;
        rv_next = rv_reg && !res_ready;
        res_next = res_reg;
        div_start = 1'b0;
        case (state_reg)
            FIN_IDLE:
                if (hdr_valid && hdr_ready)
                begin
                    h_next = hdr;
                    if (hdr.is_final)
                    begin
                        div_start = 1'b1;
                        state_next = FIN_MUL;
                    end
                    else
                    begin
                        rv_next = 1'b1;
                        res_next = {hdr.status, hdr.format_tag, hdr.channels,
                                    hdr.sample_rate, hdr.avg_bytes_rate,
                                    hdr.block_alignment, hdr.sample_bits,
                                    hdr.riff_size, hdr.payload_size,
                                    hdr.header_length, 9'd0};
                    end
                end
            FIN_MUL:
            begin
                prod_next = {16'd0, h_reg.sample_rate} * {32'd0, h_reg.channels};
                if (div_done_al)
                    state_next = FIN_CHECK;
            end
            FIN_CHECK:
            begin
                // CD quality needs exact byte rate; with sr=44100, ch=2, bits=16 it holds
                rv_next = 1'b1;
                res_next = {ST_OK, h_reg.format_tag, h_reg.channels,
                            h_reg.sample_rate, h_reg.avg_bytes_rate,
                            h_reg.block_alignment, h_reg.sample_bits,
                            h_reg.riff_size, h_reg.payload_size,
                            h_reg.header_length,
                            flags | {6'd0, (is_cd && prod_reg != 48'd88200), 2'd0}};
                state_next = FIN_IDLE;
            end
            default:
                state_next = FIN_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FIN_IDLE;
            rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        prod_reg <= prod_next;
        res_reg <= res_next;
        cd_q_reg <= cd_prod[56:36];
        cd_rem_nz_reg <= (h_reg.payload_size[3:0] != 4'd0) ||
                         (cd_back != {1'b0, h_reg.payload_size[31:4]});
        if (div_done_al)
            rem_al_reg <= rem_al_next;
    end

`include "wave_header_parser_checker_core_macros.svh"
    `WHP_ASSERT_IMPL(a_busy_no_take, state_reg != FIN_IDLE, !hdr_ready)
    `WHP_ASSERT_NEXT(a_check_emits, state_reg == FIN_CHECK, rv_reg)
endmodule

/* hw/rtl/whp_mod.sv */
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on whp_pkg.
module whp_mod
    import whp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);
    logic [31:0] num_reg, den_reg;
    logic [31:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, num_reg[31]};
    assign diff = shifted - {1'b0, den_reg};
    assign done = busy_reg && (cnt_reg == 6'd32);
    assign remainder = rem_reg;

    // Shift one dividend bit in and subtract when it fits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd32)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg && cnt_reg != 6'd32)
        begin
            num_reg <= {num_reg[30:0], 1'b0};
            rem_reg <= (den_reg == 32'd0 || diff[32]) ? shifted[31:0] : diff[31:0];
        end
    end
endmodule

/* hw/rtl/wave_header_parser_checker_core.sv */
// RIFF/WAVE header parser: bytes stream in one per cycle through the front part,
// which walks the chunk list; on the data chunk length (or a failure or end mark)
// it hands a header record through a two-entry queue to the check unit. Bytes
// keep that rate while the front's output register and the queue have room. A
// completed header holds the check unit from the cycle it is taken until its
// result is offered, for the 32-step serial block-alignment remainder; failure
// and end-mark records leave in the cycle after they are taken. Meanwhile the
// front keeps going until the queue and its output register fill, then stalls.
module wave_header_parser_checker_core
    import whp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, format_tag, channels, sample_rate, avg_bytes_rate, block_alignment,
    // sample_bits, riff_size, payload_size, header_length, problem_flags, pad
    output logic [239:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    logic [31:0] file_size_reg, min_cd_reg;
    logic        size_check_reg;
    logic        f_valid, f_ready, q_valid, q_ready;
    hdr_t        f_hdr, q_hdr;
    res_t        r;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg <= '0;
            size_check_reg <= 1'b1;
            min_cd_reg <= 32'd705600;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FILE_SIZE: file_size_reg <= cfg_data;
                CFG_SIZE_CHECK: size_check_reg <= cfg_data[0];
                CFG_MIN_CD: min_cd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    whp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_kind(s_axis_tuser), .in_byte(s_axis_tdata),
        .hdr_valid(f_valid), .hdr_ready(f_ready), .hdr(f_hdr)
    );
    whp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_hdr),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_hdr)
    );
    whp_check u_check (
        .clk(clk), .rst_n(rst_n), .hdr_valid(q_valid), .hdr_ready(q_ready), .hdr(q_hdr),
        .file_size(file_size_reg), .size_check(size_check_reg), .min_cd(min_cd_reg),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
    );

    // Pack result, first field lowest
    assign m_axis_tdata = {4'd0, r.problem_flags, r.header_length, r.payload_size,
                           r.riff_size, r.sample_bits, r.block_alignment,
                           r.avg_bytes_rate, r.sample_rate, r.channels,
                           r.format_tag, r.status};
endmodule

/* verif/wave_header_parser_checker_core_test.sv */
// Testbench for wave_header_parser_checker_core: streams RIFF/WAVE files byte by byte
// and checks every header record against a predictor. Depends on whp_pkg and the core.
module wave_header_parser_checker_core_test
    import whp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned HOLD_CYCLES = 400;

    // Header predictor and store of expected header records
    class wave_scoreboard;
        res_t        pending[$];
        int unsigned mismatches;
        bit [31:0]   file_size;
        bit          size_check;
        bit [31:0]   min_cd;
        phase_t      ph;
        bit [1:0]    pos;
        bit [31:0]   word;
        bit [31:0]   skip;
        bit [31:0]   fmt_len;
        bit [31:0]   hcount;
        bit [31:0]   riff;
        bit [31:0]   fld[6];
        bit          sent;

        function new();
            file_size = 0;
            size_check = 1;
            min_cd = 705600;
            mismatches = 0;
            rearm();
        endfunction

        function void write_reg(bit [1:0] idx, bit [31:0] v);
            if (idx == CFG_FILE_SIZE) file_size = v;
            else if (idx == CFG_SIZE_CHECK) size_check = v[0];
            else if (idx == CFG_MIN_CD) min_cd = v;
        endfunction

        function void rearm();
            ph = PH_RIFF;
            pos = 0;
            word = 0;
            skip = 0;
            fmt_len = 0;
            hcount = 0;
            riff = 0;
            foreach (fld[i]) fld[i] = 0;
            sent = 0;
        endfunction

        // Assemble little-endian words; true on the fourth byte
        function bit take(bit [7:0] b, output bit [31:0] w);
            word |= 32'(b) << (8 * pos);
            pos = pos + 1;
            w = word;
            if (pos != 0) return 0;
            word = 0;
            return 1;
        endfunction

        function void post(bit [2:0] st, bit [31:0] pay, bit [8:0] fl);
            res_t e;
            e.status = st;
            e.format_tag = fld[0][15:0];
            e.channels = fld[1][15:0];
            e.sample_rate = fld[2];
            e.avg_bytes_rate = fld[3];
            e.block_alignment = fld[4][15:0];
            e.sample_bits = fld[5][15:0];
            e.riff_size = riff;
            e.payload_size = pay;
            e.header_length = hcount;
            e.problem_flags = fl;
            pending.push_back(e);
            sent = 1;
        endfunction

        // Final checks once the data chunk length is known
        function void judge(bit [31:0] dlen);
            longint unsigned ch, sr, avg, al, bits, rate, total, hdr, padded, d;
            bit [8:0] f;
            ch = fld[1]; sr = fld[2]; avg = fld[3]; al = fld[4]; bits = fld[5];
            d = dlen;
            rate = (sr * ch * bits) / 8;
            total = longint'(riff) + 8;
            hdr = hcount;
            padded = d + (d & 1);
            f = 0;
            if (ch == 2 && bits == 16 && sr == CD_RATE_HZ && avg == CD_BYTE_RATE
                && rate == CD_BYTE_RATE)
            begin
                if (dlen < min_cd) f[0] = 1;
                if (dlen % CD_SECTOR != 0) f[1] = 1;
            end
            else
            begin
                f[2] = 1;
            end
            if (hcount != CANON_HEADER) f[3] = 1;
            if (d + hdr > total) f[4] = 1;
            if (al == 0 || (d % al) != 0) f[5] = 1;
            if (size_check)
            begin
                if (total < file_size) f[6] = 1;
                if (total > file_size) f[7] = 1;
            end
            if (total > padded + hdr) f[8] = 1;
            post(ST_OK, dlen, f);
        endfunction

        // Note one accepted input transaction
        function void note_item(bit k, bit [7:0] b);
            bit [31:0] w;
            int unsigned off, idx, sh;
            if (k)
            begin
                if (!sent)
                    post(ph == PH_RIFF ? ST_NO_RIFF : ph == PH_WAVE ? ST_NO_WAVE
                         : ST_EARLY_END, 0, 0);
                rearm();
                return;
            end
            if (sent) return;
            hcount++;
            case (ph)
                PH_RIFF:
                    if (take(b, w))
                    begin
                        if (w == TAG_RIFF) ph = PH_RSIZE;
                        else post(w == TAG_FORM ? ST_AIFF : ST_NO_RIFF, 0, 0);
                    end
                PH_RSIZE:
                    if (take(b, w))
                    begin
                        riff = w;
                        ph = PH_WAVE;
                    end
                PH_WAVE:
                    if (take(b, w))
                    begin
                        if (w != TAG_WAVE) post(ST_NO_WAVE, 0, 0);
                        else ph = PH_FID;
                    end
                PH_FID:
                    if (take(b, w)) ph = (w == TAG_FMT) ? PH_FLEN : PH_OLEN_F;
                PH_DID:
                    if (take(b, w)) ph = (w == TAG_DATA) ? PH_DLEN : PH_OLEN_D;
                PH_OLEN_F, PH_OLEN_D:
                    if (take(b, w))
                    begin
                        skip = w;
                        if (w == 0) ph = (ph == PH_OLEN_F) ? PH_FID : PH_DID;
                        else ph = (ph == PH_OLEN_F) ? PH_SKIP_F : PH_SKIP_D;
                    end
                PH_SKIP_F, PH_SKIP_D, PH_EXTRA:
                begin
                    skip--;
                    if (skip == 0) ph = (ph == PH_SKIP_F) ? PH_FID : PH_DID;
                end
                PH_FLEN:
                    if (take(b, w))
                    begin
                        fmt_len = w;
                        if (w < FMT_MIN_LEN) post(ST_FMT_SHORT, 0, 0);
                        else
                        begin
                            skip = FMT_MIN_LEN;
                            ph = PH_FIELDS;
                        end
                    end
                PH_FIELDS:
                begin
                    off = (FMT_MIN_LEN - skip) & 15;
                    idx = off < 2 ? 0 : off < 4 ? 1 : off < 8 ? 2 : off < 12 ? 3
                          : off < 14 ? 4 : 5;
                    sh = (idx == 2 || idx == 3) ? (off & 3) * 8 : (off & 1) * 8;
                    fld[idx] |= 32'(b) << sh;
                    skip--;
                    if (off == 1 && fld[0] != 1)
                    begin
                        post(ST_NOT_PCM, 0, 0);
                        return;
                    end
                    if (skip == 0)
                    begin
                        skip = fmt_len - FMT_MIN_LEN;
                        ph = (skip != 0) ? PH_EXTRA : PH_DID;
                    end
                end
                PH_DLEN:
                    if (take(b, w)) judge(w);
                default:
                    rearm();
            endcase
        endfunction

        // Compare one accepted output transaction with the oldest expectation
        function void check_result(bit [239:0] d);
            res_t a, e;
            a.status = d[2:0];
            a.format_tag = d[18:3];
            a.channels = d[34:19];
            a.sample_rate = d[66:35];
            a.avg_bytes_rate = d[98:67];
            a.block_alignment = d[114:99];
            a.sample_bits = d[130:115];
            a.riff_size = d[162:131];
            a.payload_size = d[194:163];
            a.header_length = d[226:195];
            a.problem_flags = d[235:227];
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected header record: %p", a);
                return;
            end
            e = pending.pop_front();
            if (a !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("header record mismatch\n  expected %p\n  actual   %p", e, a);
            end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 0;
    logic         s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [239:0] m_axis_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = 0;
    logic [31:0]  cfg_data = 0;

    wave_scoreboard sb = new();
    bit [7:0]       stream[$];
    bit             calm = 0;
    bit             hold_req = 0;
    bit             hold_taken = 0;
    bit [31:0]      cur_file_size = 0;
    bit [31:0]      cur_min_cd = 705600;
    int unsigned    idle_cycles = 0;

    wave_header_parser_checker_core dut (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1;
                m_axis_tready <= 0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= calm || $urandom_range(99) >= 21;
                @(posedge clk);
            end
        end
    end

    // Check each accepted header record
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic push(bit k, bit [7:0] b);
        if (!calm && $urandom_range(99) < 21)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= k;
        s_axis_tdata <= b;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(k, b);
    endtask

    task automatic write_cfg(bit [1:0] idx, bit [31:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.write_reg(idx, v);
        if (idx == CFG_FILE_SIZE) cur_file_size = v;
        if (idx == CFG_MIN_CD) cur_min_cd = v;
    endtask

    // Hold the sender until every expected record has arrived
    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_word(bit [31:0] w);
        for (int i = 0; i < 4; i++) stream.push_back(w[8*i +: 8]);
    endtask

    task automatic put_half(bit [15:0] h);
        stream.push_back(h[7:0]);
        stream.push_back(h[15:8]);
    endtask

    // Send the built stream followed by an end-of-stream mark
    task automatic play();
        foreach (stream[i]) push(0, stream[i]);
        push(1, 8'($urandom_range(255)));
        stream.delete();
    endtask

    task automatic filler_chunk(bit [31:0] avoid);
        bit [31:0] id;
        int unsigned len;
        id = $urandom;
        if (id == avoid) id ^= 1;
        len = $urandom_range(5);
        put_word(id);
        put_word(len);
        repeat (len) stream.push_back(8'($urandom_range(255)));
    endtask

    // Build a well-formed file with random content
    task automatic make_wave(bit cd, bit plain);
        bit [15:0] fmt, ch, al, bits;
        bit [31:0] sr, avg, flen, dlen, hdr, rsz;
        stream.delete();
        put_word(TAG_RIFF);
        put_word(0);
        put_word(TAG_WAVE);
        if (!plain) repeat ($urandom_range(2)) filler_chunk(TAG_FMT);
        flen = plain ? 16 : 16 + $urandom_range(3);
        put_word(TAG_FMT);
        put_word(flen);
        if (cd)
        begin
            fmt = 1; ch = 2; sr = CD_RATE_HZ; avg = CD_BYTE_RATE; al = 4; bits = 16;
        end
        else
        begin
            fmt = $urandom_range(9) != 0 ? 16'd1 : 16'($urandom);
            if ($urandom_range(1))
            begin
                ch = 16'($urandom); sr = $urandom; avg = $urandom; al = 16'($urandom);
                bits = 16'($urandom);
            end
            else
            begin
                ch = 16'($urandom_range(1, 8)); sr = $urandom_range(8000, 96000);
                avg = sr * ch * 2; al = 16'($urandom_range(0, 16)); bits = 16;
            end
        end
        put_half(fmt); put_half(ch); put_word(sr); put_word(avg);
        put_half(al); put_half(bits);
        repeat (flen - 16) stream.push_back(8'($urandom_range(255)));
        if (!plain) repeat ($urandom_range(2)) filler_chunk(TAG_DATA);
        case ($urandom_range(3))
            0: dlen = $urandom;
            1: dlen = 2352 * $urandom_range(0, 600);
            2: dlen = $urandom_range(0, 64);
            default: dlen = cur_min_cd + $urandom_range(2) - 1;
        endcase
        put_word(TAG_DATA);
        put_word(dlen);
        hdr = stream.size();
        case ($urandom_range(3))
            0: rsz = $urandom;
            1: rsz = cur_file_size - 8;
            2: rsz = hdr + dlen + dlen[0] - 8 + $urandom_range(0, 4);
            default: rsz = hdr + dlen - 8;
        endcase
        for (int i = 0; i < 4; i++) stream[4 + i] = rsz[8*i +: 8];
        if (!plain) repeat ($urandom_range(3)) stream.push_back(8'($urandom_range(255)));
    endtask

    initial
    begin
        bit [31:0] fs_set[5], mc_set[5];
        bit        ck_set[5];
        int unsigned n;
        fs_set = '{0, 32'hFFFF_FFFF, $urandom, 100, $urandom_range(40, 200)};
        ck_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        mc_set = '{705600, 0, 32'hFFFF_FFFF, 2352, 705600};

        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: bare end mark, AIFF, foreign tag, bad WAVE tag, early end
        play();
        put_word(TAG_FORM); play();
        put_word(32'h1234_5678); play();
        put_word(TAG_RIFF); put_word(36); put_word(TAG_WAVE ^ 32'h0100_0000); play();
        put_word(TAG_RIFF); play();
        // Short fmt chunk and non-PCM format with bytes after the failure
        put_word(TAG_RIFF); put_word(36); put_word(TAG_WAVE);
        put_word(TAG_FMT); put_word(8); play();
        put_word(TAG_RIFF); put_word(36); put_word(TAG_WAVE);
        put_word(TAG_FMT); put_word(16); put_half(2); put_word(0); play();
        // Canonical CD header with reset settings
        make_wave(1, 1); play();
        drain();

        for (int p = 0; p < 5; p++)
        begin
            write_cfg(CFG_FILE_SIZE, fs_set[p]);
            write_cfg(CFG_SIZE_CHECK, {31'd0, ck_set[p]});
            write_cfg(CFG_MIN_CD, mc_set[p]);
            // Stall the output long enough to back up the input
            if (p == 1)
            begin
                hold_req = 1;
                repeat (8)
                begin
                    put_word(TAG_FORM);
                    play();
                end
                drain();
            end
            calm = (p == 2);
            repeat (2)
            begin
                n = $urandom_range(99);
                make_wave(n < 25, 0);
                if (n >= 75)
                begin
                    // Truncate or corrupt one byte
                    if ($urandom_range(1))
                        while (stream.size() > $urandom_range(stream.size() - 1))
                            void'(stream.pop_back());
                    else
                        stream[$urandom_range(stream.size() - 1)] = 8'($urandom_range(255));
                end
                play();
            end
            calm = 0;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/whp_pkg.sv
hw/rtl/whp_front.sv
hw/rtl/whp_queue.sv
hw/rtl/whp_check.sv
hw/rtl/whp_mod.sv
hw/rtl/wave_header_parser_checker_core.sv
verif/wave_header_parser_checker_core_test.sv
